// ----- rtl/core/log_record_deframer_crc32_assert.svh -----
// Assertion macros for the log record deframer.
// Included by the top level; needs no other file.
`ifndef LOG_RECORD_DEFRAMER_CRC32_ASSERT_SVH
`define LOG_RECORD_DEFRAMER_CRC32_ASSERT_SVH
`ifndef SYNTH
`define LRD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");
`define LRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");
`else
`define LRD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define LRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/lrd_pkg.sv -----
// Shared types, codes and the CRC-32 byte update for the log record deframer.
// No dependencies.
`timescale 1ns / 1ps

package lrd_pkg;

	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] ADD_OPCODE_IDX    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] DELETE_OPCODE_IDX = 8'd1;

	localparam logic [7:0]  ADD_OPCODE_RST    = 8'h00;
	localparam logic [7:0]  DELETE_OPCODE_RST = 8'h01;
	localparam logic [31:0] CRC_POLY          = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT          = 32'hFFFFFFFF;
	localparam logic [31:0] FIELD_BYTES       = 32'd4;
	localparam logic [31:0] MIN_PAYLOAD       = 32'd5;

	typedef enum logic [1:0] {
		PH_LENGTH  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CRC     = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_ADD     = 3'd0,
		ST_DELETE  = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_BADCRC  = 3'd3,
		ST_TRUNC   = 3'd4
	} status_t;

	// Reflected CRC-32, one byte, bit at a time.
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/lrd_ifs.sv -----
// Channel interfaces of the log record deframer: byte input, record result
// and configuration write. Depends on lrd_pkg.
`timescale 1ns / 1ps

interface lrd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface lrd_rec_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] doc_id;
	logic [31:0] payload_length;
	logic        end_of_log;
	modport source (output valid, status, doc_id, payload_length, end_of_log, input ready);
	modport sink (input valid, status, doc_id, payload_length, end_of_log, output ready);
endinterface

interface lrd_cfg_if
	import lrd_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           wdata;
	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

// ----- rtl/core/log_record_deframer_crc32.sv -----
// Log record deframer with CRC-32 check: top level.
// Depends on lrd_pkg, lrd_ifs and log_record_deframer_crc32_assert.svh.
//
// Usage:
//   byte_ch carries the log body one byte per transfer, with last_byte set
//   on the final byte. rec_ch carries one result per finished record, per
//   CRC failure, or per log that ends inside a record. cfg_ch writes the
//   add opcode (index 0) and delete opcode (index 1); other indexes are
//   ignored, and the channel is always ready.
//   Throughput is one byte per cycle: the CRC byte update, the 32-bit
//   byte counter compare and the field capture are all combinational,
//   in front of the framing state registers.
//   A result is valid in the cycle after the transfer of the byte that
//   causes it, held in the result register.
//   When the receiver stalls, bytes are still taken as long as the result
//   register is empty or being drained; a byte arriving while a result
//   waits and rec_ch.ready is low is held off.
//   Reset clears the framing state, the stop flag and the opcodes to 0 and
//   1. After a CRC mismatch every later byte is taken and dropped until
//   reset; any other end of log restarts framing for a new log body.
`timescale 1ns / 1ps
`include "log_record_deframer_crc32_assert.svh"

module log_record_deframer_crc32
	import lrd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	lrd_byte_if.sink   byte_ch,
	lrd_rec_if.source  rec_ch,
	lrd_cfg_if.sink    cfg_ch
);

	logic [7:0]  add_opcode_q, delete_opcode_q;
	phase_t      phase_q, phase_n;
	logic        stopped_q, stopped_n;
	logic [31:0] cnt_q, cnt_n, cnt_inc;
	logic [31:0] len_q, len_n;
	logic [31:0] crc_q, crc_n;
	logic [7:0]  op_q, op_n;
	logic [31:0] doc_q, doc_n;
	logic [31:0] rx_q, rx_n;
	logic [1:0]  doc_slot;

	logic        res_valid;
	status_t     res_status;
	logic [31:0] res_id, res_len;
	logic        res_eol;
	logic        done;

	logic        out_valid_q;
	status_t     out_status_q;
	logic [31:0] out_id_q, out_len_q;
	logic        out_eol_q;

	logic        byte_xfer;

	assign byte_ch.ready = !out_valid_q || rec_ch.ready;
	assign byte_xfer     = byte_ch.valid && byte_ch.ready;
	assign cfg_ch.ready  = 1'b1;

	assign cnt_inc  = cnt_q + 32'd1;
	assign doc_slot = cnt_q[1:0] - 2'd1;

	always_comb begin
		phase_n    = phase_q;
		stopped_n  = stopped_q;
		cnt_n      = cnt_q;
		len_n      = len_q;
		crc_n      = crc_q;
		op_n       = op_q;
		doc_n      = doc_q;
		rx_n       = rx_q;
		res_valid  = 1'b0;
		res_status = ST_UNKNOWN;
		res_id     = '0;
		res_len    = '0;
		res_eol    = 1'b0;
		done       = 1'b0;
		if (!stopped_q) begin
			case (phase_q)
				PH_PAYLOAD: begin
					crc_n = crc32_byte(crc_q, byte_ch.data_byte);
					if (cnt_q == '0) begin
						op_n = byte_ch.data_byte;
					end else if (cnt_q <= FIELD_BYTES) begin
						doc_n[{doc_slot, 3'b000} +: 8] = byte_ch.data_byte;
					end
					if (cnt_inc == len_q) begin
						phase_n = PH_CRC;
						cnt_n   = '0;
					end else begin
						cnt_n = cnt_inc;
					end
				end
				PH_CRC: begin
					rx_n[{cnt_q[1:0], 3'b000} +: 8] = byte_ch.data_byte;
					cnt_n = cnt_inc;
					if (cnt_inc == FIELD_BYTES) begin
						done      = 1'b1;
						res_valid = 1'b1;
						res_len   = len_q;
						if (rx_n != ~crc_q) begin
							res_status = ST_BADCRC;
							res_eol    = 1'b1;
							stopped_n  = 1'b1;
						end else begin
							res_eol = byte_ch.last_byte;
							if (len_q < MIN_PAYLOAD) begin
								res_status = ST_UNKNOWN;
							end else if (op_q == add_opcode_q) begin
								res_status = ST_ADD;
								res_id     = doc_q;
							end else if (op_q == delete_opcode_q) begin
								res_status = ST_DELETE;
								res_id     = doc_q;
							end else begin
								res_status = ST_UNKNOWN;
							end
							phase_n = PH_LENGTH;
							cnt_n   = '0;
							len_n   = '0;
							crc_n   = CRC_INIT;
							op_n    = '0;
							doc_n   = '0;
							rx_n    = '0;
						end
					end
				end
				default: begin
					// The unused phase code behaves as the length field phase.
					len_n[{cnt_q[1:0], 3'b000} +: 8] = byte_ch.data_byte;
					cnt_n = cnt_inc;
					if (cnt_inc == FIELD_BYTES) begin
						cnt_n   = '0;
						crc_n   = CRC_INIT;
						op_n    = '0;
						doc_n   = '0;
						rx_n    = '0;
						phase_n = (len_n == '0) ? PH_CRC : PH_PAYLOAD;
					end
				end
			endcase
			if (!done && byte_ch.last_byte) begin
				res_valid  = 1'b1;
				res_status = ST_TRUNC;
				res_id     = '0;
				res_len    = '0;
				res_eol    = 1'b1;
				phase_n    = PH_LENGTH;
				cnt_n      = '0;
				len_n      = '0;
				crc_n      = CRC_INIT;
				op_n       = '0;
				doc_n      = '0;
				rx_n       = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LENGTH;
			stopped_q <= 1'b0;
			cnt_q     <= '0;
			len_q     <= '0;
			crc_q     <= CRC_INIT;
			op_q      <= '0;
			doc_q     <= '0;
			rx_q      <= '0;
		end else if (byte_xfer) begin
			phase_q   <= phase_n;
			stopped_q <= stopped_n;
			cnt_q     <= cnt_n;
			len_q     <= len_n;
			crc_q     <= crc_n;
			op_q      <= op_n;
			doc_q     <= doc_n;
			rx_q      <= rx_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_opcode_q    <= ADD_OPCODE_RST;
			delete_opcode_q <= DELETE_OPCODE_RST;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				ADD_OPCODE_IDX:    add_opcode_q    <= cfg_ch.wdata;
				DELETE_OPCODE_IDX: delete_opcode_q <= cfg_ch.wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (byte_xfer && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (rec_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_xfer && res_valid) begin
			out_status_q <= res_status;
			out_id_q     <= res_id;
			out_len_q    <= res_len;
			out_eol_q    <= res_eol;
		end
	end

	assign rec_ch.valid          = out_valid_q;
	assign rec_ch.status         = out_status_q;
	assign rec_ch.doc_id         = out_id_q;
	assign rec_ch.payload_length = out_len_q;
	assign rec_ch.end_of_log     = out_eol_q;

	// Once stopped, no new result may ever appear.
	`LRD_ASSERT_NEXT(a_stop_silent, clk, arst_n, stopped_q && !out_valid_q, !out_valid_q && stopped_q)
	// A CRC failure always closes the log.
	`LRD_ASSERT_IMPLIES(a_badcrc_eol, clk, arst_n, out_valid_q && out_status_q == ST_BADCRC, out_eol_q)
	// While running, length and CRC fields count no further than four bytes.
	`LRD_ASSERT_IMPLIES(a_field_cnt, clk, arst_n, !stopped_q && (phase_q == PH_LENGTH || phase_q == PH_CRC), cnt_q < FIELD_BYTES)

endmodule
